[src/oit_pkg.sv]
// oit_pkg: shared types and constants for the interval overlay table
// no dependencies
`timescale 1ns / 1ps

package oit_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_BAD_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [23:0] region_start;
    logic [23:0] region_end;
    logic [7:0]  fg_brush;
    logic [7:0]  bg_brush;
    logic [5:0]  read_slot;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [23:0] slot_start;
    logic [23:0] slot_end;
    logic [7:0]  slot_fg;
    logic [7:0]  slot_bg;
    logic [6:0]  region_count;
  } out_beat_t;

  typedef struct packed {
    logic [23:0] start;
    logic [23:0] stop;
    logic [7:0]  fg;
    logic [7:0]  bg;
  } entry_t;

endpackage

[src/oit_ram.sv]
// oit_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module oit_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/interval_overlay_table_top.sv]
// interval_overlay_table_top: sorted interval table with overlaying insert and slot read
// depends on oit_pkg and oit_ram
`timescale 1ns / 1ps

// channel   ports                        handshake
// input     start, busy, in_beat         beat taken when start high and busy low
// result    out_valid, out_beat          one-cycle strobe, receiver cannot stall
//
// a read waits in S_RDWAIT for the registered ram read; a rejected insert answers from idle
// an insert walks every held entry through the ping-pong banks: S_FETCH and S_LOAD fetch
// each entry, then S_EMIT writes its pieces one by one and is entered even when the entry
// is dropped; S_FIN and S_COMMIT then finish
// reset is synchronous, active low; it empties the table, no clearing pass needed
// busy drops in the cycle the result strobe is shown, so the next beat may follow

module interval_overlay_table_top #(
  parameter int TABLE_DEPTH = oit_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  oit_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  output oit_pkg::out_beat_t out_beat
);

  localparam int AW = $clog2(TABLE_DEPTH);
  // piece count may reach depth plus two before the overflow check
  localparam int NW = $clog2(TABLE_DEPTH + 3);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RDWAIT = 7'b0000010,
    S_FETCH  = 7'b0000100,
    S_LOAD   = 7'b0001000,
    S_EMIT   = 7'b0010000,
    S_FIN    = 7'b0100000,
    S_COMMIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // bank_r selects the bank that holds the live table; inserts write the other one
  logic bank_r, bank_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic [NW-1:0] n_r, n_nxt;       // pieces written to the shadow bank
  logic [NW-1:0] idx_r, idx_nxt;   // entry being walked
  logic placed_r, placed_nxt;
  oit_pkg::in_beat_t req_r, req_nxt;
  oit_pkg::entry_t lpc_r, lpc_nxt, rpc_r, rpc_nxt;
  logic lp_r, lp_nxt, np_r, np_nxt, rp_r, rp_nxt;
  logic out_valid_r, out_valid_nxt;
  oit_pkg::out_beat_t out_r, out_nxt;

  // ram signals
  logic            rd_en;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  oit_pkg::entry_t wr_data;
  logic [63:0]     rd_a, rd_b;
  oit_pkg::entry_t cur;
  oit_pkg::entry_t new_ent;

  oit_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_bank_a (
    .clk  (clk),
    .we   (wr_en & bank_r),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_a)
  );

  oit_ram #(.WIDTH(64), .DEPTH(TABLE_DEPTH)) u_bank_b (
    .clk  (clk),
    .we   (wr_en & ~bank_r),
    .waddr(wr_addr),
    .wdata(wr_data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_b)
  );

  assign cur     = bank_r ? oit_pkg::entry_t'(rd_b) : oit_pkg::entry_t'(rd_a);
  assign new_ent = '{start: req_r.region_start, stop: req_r.region_end,
                     fg: req_r.fg_brush, bg: req_r.bg_brush};
  assign wr_addr = n_r[AW-1:0];

  always_comb begin
    logic lt, gt;
    state_nxt     = state_r;
    bank_nxt      = bank_r;
    count_nxt     = count_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    placed_nxt    = placed_r;
    req_nxt       = req_r;
    lpc_nxt       = lpc_r;
    rpc_nxt       = rpc_r;
    lp_nxt        = lp_r;
    np_nxt        = np_r;
    rp_nxt        = rp_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    wr_en         = 1'b0;
    wr_data       = new_ent;
    lt            = cur.stop < req_r.region_start;
    gt            = cur.start > req_r.region_end;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt = in_beat;
          out_nxt = '0;
          out_nxt.region_count = 7'(count_r);
          if (in_beat.operation == oit_pkg::OP_READ) begin
            // compare at full width so a small table never aliases a high slot
            if (32'(in_beat.read_slot) < 32'(count_r)) begin
              rd_en     = 1'b1;
              rd_addr   = AW'(in_beat.read_slot);
              state_nxt = S_RDWAIT;
            end else begin
              out_nxt.status = oit_pkg::ST_EMPTY;
              out_valid_nxt  = 1'b1;
            end
          end else if (in_beat.region_end < in_beat.region_start) begin
            out_nxt.status = oit_pkg::ST_BAD_RANGE;
            out_valid_nxt  = 1'b1;
          end else begin
            n_nxt      = '0;
            idx_nxt    = '0;
            placed_nxt = 1'b0;
            state_nxt  = (count_r == '0) ? S_FIN : S_FETCH;
          end
        end
      end

      S_RDWAIT: begin
        out_nxt.status     = oit_pkg::ST_OK;
        out_nxt.slot_start = cur.start;
        out_nxt.slot_end   = cur.stop;
        out_nxt.slot_fg    = cur.fg;
        out_nxt.slot_bg    = cur.bg;
        out_valid_nxt      = 1'b1;
        state_nxt          = S_IDLE;
      end

      S_FETCH: begin
        rd_en     = 1'b1;
        state_nxt = S_LOAD;
      end

      // split the live entry into left piece, new interval and right piece
      S_LOAD: begin
        lp_nxt  = lt | (~gt & (cur.start < req_r.region_start));
        lpc_nxt = cur;
        if (!lt) begin
          lpc_nxt.stop = req_r.region_start - 24'd1;
        end
        np_nxt  = ~lt & ~placed_r;
        rp_nxt  = gt | (~lt & (cur.stop > req_r.region_end));
        rpc_nxt = cur;
        if (!gt) begin
          rpc_nxt.start = req_r.region_end + 24'd1;
        end
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        if (lp_r) begin
          wr_data = lpc_r;
          lp_nxt  = 1'b0;
        end else if (np_r) begin
          wr_data    = new_ent;
          np_nxt     = 1'b0;
          placed_nxt = 1'b1;
        end else begin
          wr_data = rpc_r;
          rp_nxt  = 1'b0;
        end
        if (lp_r | np_r | rp_r) begin
          wr_en = n_r < NW'(TABLE_DEPTH);
          n_nxt = n_r + NW'(1);
        end
        if (!(lp_nxt | np_nxt | rp_nxt)) begin
          if (idx_r + NW'(1) < count_r) begin
            idx_nxt   = idx_r + NW'(1);
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        if (!placed_r) begin
          wr_en      = n_r < NW'(TABLE_DEPTH);
          n_nxt      = n_r + NW'(1);
          placed_nxt = 1'b1;
        end
        state_nxt = S_COMMIT;
      end

      S_COMMIT: begin
        if (n_r > NW'(TABLE_DEPTH)) begin
          out_nxt.status = oit_pkg::ST_FULL;
        end else begin
          out_nxt.status       = oit_pkg::ST_OK;
          bank_nxt             = ~bank_r;
          count_nxt            = n_r;
          out_nxt.region_count = 7'(n_r);
        end
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bank_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      lp_r        <= 1'b0;
      np_r        <= 1'b0;
      rp_r        <= 1'b0;
      placed_r    <= 1'b0;
      n_r         <= '0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      lp_r        <= lp_nxt;
      np_r        <= np_nxt;
      rp_r        <= rp_nxt;
      placed_r    <= placed_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
    end
    req_r <= req_nxt;
    lpc_r <= lpc_nxt;
    rpc_r <= rpc_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

endmodule

[src/oit_checker.sv]
// oit_checker: port-level assertions for the interval overlay table, with its bind
// depends on oit_pkg and interval_overlay_table_top
`timescale 1ns / 1ps

module oit_checker #(
  parameter int TABLE_DEPTH = oit_pkg::TABLE_DEPTH_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input oit_pkg::out_beat_t out_beat
);

  // count never exceeds the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_beat.region_count) <= 32'(TABLE_DEPTH % 128)
                   || TABLE_DEPTH >= 128))
    else $error("region count beyond table depth");

  // only a good read carries entry data
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.status != oit_pkg::ST_OK) |->
      (out_beat.slot_start == '0 && out_beat.slot_end == '0 &&
       out_beat.slot_fg == '0 && out_beat.slot_bg == '0))
    else $error("entry fields set on a failed item");

  // the result strobe ends the work, so busy is low with it
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("busy while result shown");

  // work only begins on an accepted beat
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy without a start");

endmodule

bind interval_overlay_table_top oit_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_oit_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_beat (out_beat)
);

[tb/sv/interval_overlay_table_top_tb.sv]
// interval_overlay_table_top_tb: self-checking bench for the interval overlay table
// depends on oit_pkg and interval_overlay_table_top
// directed table then random inserts and reads
`timescale 1ns / 1ps

module interval_overlay_table_top_tb;
  import oit_pkg::*;

  localparam int DEPTH      = TABLE_DEPTH_DEF;
  localparam int N_RANDOM   = 1400;
  localparam int WDOG_LIMIT = 20000;
  localparam int DRAIN_CYC  = 4 * DEPTH + 20;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  out_beat_t out_beat;

  always #4 clk = ~clk;

  interval_overlay_table_top #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_beat(in_beat), .out_valid(out_valid), .out_beat(out_beat)
  );

  // shadow copy of the sorted table
  entry_t   span_tab [DEPTH];
  int       span_cnt;
  entry_t   merge_buf [DEPTH + 2];

  out_beat_t pending_q [$];
  int        n_errors = 0;
  int        n_row_err;
  int        idle_pct;
  int        wdog = 0;

  function automatic logic [1:0] overlay_insert(input logic [23:0] s, input logic [23:0] e,
                                                input logic [7:0] fg, input logic [7:0] bg);
    int     n;
    bit     placed;
    entry_t c;
    n = 0;
    placed = 1'b0;
    if (e < s) return ST_BAD_RANGE;
    for (int i = 0; i < span_cnt; i++) begin
      c = span_tab[i];
      if (c.stop < s) begin
        if (n < DEPTH + 2) merge_buf[n] = c;
        n++;
      end else if (c.start > e) begin
        if (!placed) begin
          if (n < DEPTH + 2) merge_buf[n] = '{s, e, fg, bg};
          n++;
          placed = 1'b1;
        end
        if (n < DEPTH + 2) merge_buf[n] = c;
        n++;
      end else begin
        if (c.start < s) begin
          if (n < DEPTH + 2) merge_buf[n] = '{c.start, s - 24'd1, c.fg, c.bg};
          n++;
        end
        if (!placed) begin
          if (n < DEPTH + 2) merge_buf[n] = '{s, e, fg, bg};
          n++;
          placed = 1'b1;
        end
        if (c.stop > e) begin
          if (n < DEPTH + 2) merge_buf[n] = '{e + 24'd1, c.stop, c.fg, c.bg};
          n++;
        end
      end
    end
    if (!placed) begin
      if (n < DEPTH + 2) merge_buf[n] = '{s, e, fg, bg};
      n++;
    end
    if (n > DEPTH) return ST_FULL;
    for (int i = 0; i < n; i++) span_tab[i] = merge_buf[i];
    span_cnt = n;
    return ST_OK;
  endfunction

  function automatic out_beat_t table_step(input in_beat_t b);
    out_beat_t r;
    r = '0;
    if (b.operation == OP_INSERT) begin
      r.status = overlay_insert(b.region_start, b.region_end, b.fg_brush, b.bg_brush);
    end else if (b.read_slot < span_cnt) begin
      r.status     = ST_OK;
      r.slot_start = span_tab[b.read_slot].start;
      r.slot_end   = span_tab[b.read_slot].stop;
      r.slot_fg    = span_tab[b.read_slot].fg;
      r.slot_bg    = span_tab[b.read_slot].bg;
    end else begin
      r.status = ST_EMPTY;
    end
    r.region_count = 7'(span_cnt);
    return r;
  endfunction

  // result side: the strobe lasts one cycle, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result beat %h", out_beat);
      end else begin
        out_beat_t exp_b;
        exp_b = pending_q.pop_front();
        if (exp_b !== out_beat) begin
          n_errors++;
          if (n_errors <= 10)
            $display({"mismatch: exp st=%0d s=%h e=%h fg=%h bg=%h n=%0d,",
                      " got st=%0d s=%h e=%h fg=%h bg=%h n=%0d"},
                     exp_b.status, exp_b.slot_start, exp_b.slot_end, exp_b.slot_fg,
                     exp_b.slot_bg, exp_b.region_count, out_beat.status, out_beat.slot_start,
                     out_beat.slot_end, out_beat.slot_fg, out_beat.slot_bg,
                     out_beat.region_count);
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("interval_overlay_table_top regression: fail");
      $finish;
    end
  end

  // send one beat, honouring the sender idle ratio; start stays high until taken
  // and is dropped by the next idle cycle or by the drain
  task automatic send_beat(input in_beat_t b, input bit has_fixed, input out_beat_t fixed_b);
    out_beat_t p;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_beat <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    p = table_step(b);
    if (has_fixed && p !== fixed_b) begin
      n_row_err++;
      if (n_row_err <= 10) $display("directed row expectation differs from shadow: %h", p);
    end
    pending_q.push_back(p);
    @(negedge clk);
  endtask

  function automatic in_beat_t mk_ins(input logic [23:0] s, input logic [23:0] e,
                                      input logic [7:0] fg, input logic [7:0] bg);
    in_beat_t b;
    b = '0;
    b.operation = OP_INSERT;
    b.region_start = s; b.region_end = e; b.fg_brush = fg; b.bg_brush = bg;
    b.read_slot = 6'($urandom);
    return b;
  endfunction

  function automatic in_beat_t mk_rd(input logic [5:0] slot);
    in_beat_t b;
    b = in_beat_t'($bits(in_beat_t)'({$urandom, $urandom, $urandom}));
    b.operation = OP_READ;
    b.read_slot = slot;
    return b;
  endfunction

  function automatic out_beat_t mk_res(input logic [1:0] st, input logic [23:0] s,
                                       input logic [23:0] e, input logic [7:0] fg,
                                       input logic [7:0] bg, input logic [6:0] n);
    return '{st, s, e, fg, bg, n};
  endfunction

  // directed stimulus row: beat, whether a typed expectation exists, the expectation
  typedef struct {
    in_beat_t  beat;
    bit        has_fixed;
    out_beat_t fixed;
  } dir_row_t;

  dir_row_t dir_rows [$];

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYC) @(negedge clk);
  endtask

  initial begin
    in_beat_t  b;
    logic [23:0] s, e, w;
    int        phase;
    n_row_err = 0;
    span_cnt = 0;
    idle_pct = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table, extremes, bad range, split, trim, cover, both sides
    dir_rows.push_back('{mk_rd(6'd0), 1, mk_res(ST_EMPTY, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_rd(6'd63), 1, mk_res(ST_EMPTY, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_ins(24'd10, 24'd9, 8'hff, 8'h00), 1,
                         mk_res(ST_BAD_RANGE, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_ins(24'hffffff, 24'h0, 8'h1, 8'h1), 1,
                         mk_res(ST_BAD_RANGE, 0, 0, 0, 0, 0)});
    dir_rows.push_back('{mk_ins(24'h0, 24'hffffff, 8'hff, 8'hff), 1,
                         mk_res(ST_OK, 0, 0, 0, 0, 1)});
    dir_rows.push_back('{mk_rd(6'd0), 1,
                         mk_res(ST_OK, 24'h0, 24'hffffff, 8'hff, 8'hff, 1)});
    dir_rows.push_back('{mk_ins(24'd100, 24'd200, 8'h5a, 8'ha5), 0, '0});
    dir_rows.push_back('{mk_rd(6'd0), 0, '0});
    dir_rows.push_back('{mk_rd(6'd1), 0, '0});
    dir_rows.push_back('{mk_rd(6'd2), 0, '0});
    dir_rows.push_back('{mk_rd(6'd3), 0, '0});
    dir_rows.push_back('{mk_ins(24'd150, 24'd300, 8'h11, 8'h22), 0, '0});
    dir_rows.push_back('{mk_ins(24'd50, 24'd120, 8'h33, 8'h44), 0, '0});
    dir_rows.push_back('{mk_ins(24'd40, 24'd400, 8'h00, 8'h00), 0, '0});
    dir_rows.push_back('{mk_ins(24'd40, 24'd40, 8'h80, 8'h01), 0, '0});
    dir_rows.push_back('{mk_ins(24'hffffff, 24'hffffff, 8'h7f, 8'hfe), 0, '0});
    dir_rows.push_back('{mk_ins(24'h0, 24'h0, 8'haa, 8'h55), 0, '0});
    for (int i = 0; i < 6; i++) dir_rows.push_back('{mk_rd(6'(i)), 0, '0});
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].has_fixed, dir_rows[i].fixed);

    // random part over idling phases; small random inserts push the table to full
    for (int n = 0; n < N_RANDOM; n++) begin
      phase = (n / 200) % 4;
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 80;
        2: idle_pct = 33;
        default: idle_pct = $urandom_range(1) ? 0 : 50;
      endcase
      case ($urandom_range(9))
        0, 1, 2: begin
          // small intervals so the table fills and full rejection is reached
          s = 24'($urandom_range(4095));
          e = s + 24'($urandom_range(15));
          b = mk_ins(s, e, 8'($urandom), 8'($urandom));
        end
        3: begin
          // wide cover removes many entries
          s = 24'($urandom_range(2047));
          w = 24'($urandom_range(2048));
          b = mk_ins(s, s + w, 8'($urandom), 8'($urandom));
        end
        4: begin
          s = 24'($urandom);
          e = 24'($urandom);
          b = mk_ins(s, e, 8'($urandom), 8'($urandom));
        end
        5: begin
          s = 24'hffffff - 24'($urandom_range(31));
          b = mk_ins(s, 24'hffffff, 8'($urandom), 8'($urandom));
        end
        default: begin
          if ($urandom_range(3) == 0) b = mk_rd(6'($urandom));
          else b = mk_rd(6'($urandom_range(span_cnt > 0 ? span_cnt - 1 : 0)));
        end
      endcase
      send_beat(b, 0, '0);
    end

    wait_drained();
    if (n_errors == 0 && n_row_err == 0)
      $display("interval_overlay_table_top regression: pass");
    else $display("interval_overlay_table_top regression: fail");
    $finish;
  end

endmodule

[sim.f]
src/oit_pkg.sv
src/oit_ram.sv
src/interval_overlay_table_top.sv
src/oit_checker.sv
tb/sv/interval_overlay_table_top_tb.sv
